// ===== src/aact_pkg.sv =====
// ---------------------------------------------------------------------------
// AABB collision table package
// Shared types, codes and field layouts for the collision table block.
// ---------------------------------------------------------------------------
`default_nettype none

package aact_pkg;

    // Stream widths and input field offsets inside tdata.
    localparam int IN_TDATA_W  = 360;
    localparam int OUT_TDATA_W = 16;
    localparam int CMD_W       = 3;
    localparam int OFS_SLOT    = 0;
    localparam int OFS_MIN     = 6;
    localparam int OFS_MAX     = 54;
    localparam int OFS_ROWS    = 102;

    // Saturation limits of a Q-format coordinate.
    localparam logic [15:0] POS_MAX = 16'h7FFF;
    localparam logic [15:0] NEG_MIN = 16'h8000;

    typedef logic [2:0][15:0]       t_vec3;
    typedef logic [3:0][3:0][15:0]  t_mat;

    typedef struct packed {
        t_vec3 hi;
        t_vec3 lo;
    } t_box;

    typedef enum logic [2:0] {
        CMD_ADD   = 3'd0,
        CMD_SET   = 3'd1,
        CMD_GROW  = 3'd2,
        CMD_XFORM = 3'd3,
        CMD_QUERY = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_FULL    = 2'd1,
        STS_BADSLOT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_ADD,
        RES_FULL,
        RES_BADSLOT,
        RES_HIT
    } t_res;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CORNER,
        ST_MAC,
        ST_FLUSH,
        ST_DIV,
        ST_WAIT,
        ST_MINMAX,
        ST_BOX_DONE,
        ST_OBJ_RD,
        ST_RESULT
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic       load_in;
        logic       add_obj;
        logic       set_mat;
        logic       grow;
        logic       box_init;
        logic       sel_obj;
        logic       acc_clr;
        logic       mac_en;
        logic [1:0] mac_row;
        logic [1:0] mac_col;
        logic [2:0] corner;
        logic       div_start;
        logic       minmax;
        logic       store_char;
        logic       store_ctx;
        logic       rd_en;
        logic       obj_clr;
        logic       obj_inc;
        logic       res_load;
        t_res       res_kind;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        t_cmd cmd;
        logic full;
        logic slot_bad;
        logic obj_none;
        logic obj_last;
        logic div_busy;
        logic overlap;
        logic out_busy;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== src/aabb_transform_collision_table.sv =====
// Add, set matrix, grow and unknown commands go through a decode state and
// then give their result once the output register is free. A box transform
// works corner by corner (16 products on one shared multiplier, then 16-step
// serial dividers, skipped for zero w or overflow); a query transforms up to
// (objects + 1) boxes, the character box first.
// One item at a time. Reset: synchronous, active low; empty character box, empty table.
// ---------------------------------------------------------------------------
// AABB collision table top level
// Controller and datapath of the box transform and collision table.
// ---------------------------------------------------------------------------
`default_nettype none

module aabb_transform_collision_table
    import aact_pkg::*;
#(
    parameter int MAX_OBJECTS = 64,
    parameter int FRAC_BITS   = 8
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    // slot, min_x, min_y, min_z, max_x, max_y, max_z, row0..row3, zero pad
    input  wire [IN_TDATA_W-1:0]   s_axis_tdata,
    // command
    input  wire [CMD_W-1:0]        s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    // status, new_slot, hit, hit_slot, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Command sequencer.
    aact_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd)
    );

    // Stores, arithmetic and output register.
    aact_dp #(
        .MAX_OBJECTS(MAX_OBJECTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_in_tdata  (s_axis_tdata),
        .i_in_tuser  (s_axis_tuser),
        .o_out_tdata (m_axis_tdata),
        .o_out_tvalid(m_axis_tvalid),
        .i_out_tready(m_axis_tready)
    );

`ifndef ASSERT_OFF
    // One item at a time: no transfer in the cycle after one was taken.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken twice in a row");

    // Status code is always a defined one.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
        else $error("undefined status code");

    // A hit is only reported with an ok status and no new slot.
    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[8]) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("hit with non-zero status or slot");
`endif

endmodule

`default_nettype wire

// ===== src/aact_div.sv =====
// ---------------------------------------------------------------------------
// AABB collision table divider
// Bit-serial signed divide of (num * 2^FRAC_BITS) by den, truncated toward
// zero and saturated to 16 bits; zero and overflowing cases finish at once.
// ---------------------------------------------------------------------------
`default_nettype none

module aact_div
    import aact_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire signed [33:0] i_num,
    input  wire signed [33:0] i_den,
    output logic              o_busy,
    output logic [15:0]       o_quo
);

    localparam int NW = 34 + FRAC_BITS;
    localparam int DW = 34 + 16;
    localparam int CW = (NW > DW) ? NW : DW;

    logic [CW-1:0] r_rem, r_dsh;
    logic [15:0]   r_q;
    logic [4:0]    r_cnt;
    logic          r_neg;
    logic          r_busy;
    logic [15:0]   r_quo;

    logic signed [CW-1:0] num_ext, den_ext;
    logic [CW-1:0]        mag_n, mag_d;
    logic                 ge;
    logic [15:0]          q_next;

    // Saturate an unsigned quotient magnitude with its sign.
    function automatic logic [15:0] sat_q(input logic [15:0] mag, input logic neg);
        logic [15:0] res;
        if (neg) begin
            res = (mag > 16'h8000) ? NEG_MIN : 16'(-mag);
        end else begin
            res = (mag > 16'h7FFF) ? POS_MAX : mag;
        end
        return res;
    endfunction

    // Operand magnitudes.
    always_comb begin
        num_ext = CW'($signed({i_num, {FRAC_BITS{1'b0}}}));
        den_ext = CW'(i_den);
        mag_n   = num_ext[CW-1] ? CW'(-num_ext) : CW'(num_ext);
        mag_d   = den_ext[CW-1] ? CW'(-den_ext) : CW'(den_ext);
        ge      = (r_rem >= r_dsh);
        q_next  = {r_q[14:0], ge};
    end

    // Control state of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= (i_den != '0) && (mag_n < (mag_d << 16));
            r_cnt  <= 5'd16;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 5'd1;
            r_busy <= (r_cnt != 5'd1);
        end
    end

    // Remainder, quotient and result.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= mag_n;
            r_dsh <= mag_d << 15;
            r_q   <= '0;
            r_neg <= i_num[33] ^ i_den[33];
            if (i_den == '0) begin
                r_quo <= i_num[33] ? NEG_MIN : ((i_num != '0) ? POS_MAX : 16'h0000);
            end else if (mag_n >= (mag_d << 16)) begin
                r_quo <= (i_num[33] ^ i_den[33]) ? NEG_MIN : POS_MAX;
            end
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh <= r_dsh >> 1;
            r_q   <= q_next;
            if (r_cnt == 5'd1) begin
                r_quo <= sat_q(q_next, r_neg);
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// ===== src/aact_dp.sv =====
// ---------------------------------------------------------------------------
// AABB collision table datapath
// Box and matrix stores, shared multiplier with accumulators, three dividers,
// min/max collection, overlap test and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module aact_dp
    import aact_pkg::*;
#(
    parameter int MAX_OBJECTS = 64,
    parameter int FRAC_BITS   = 8
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    input  wire [IN_TDATA_W-1:0]   i_in_tdata,
    input  wire [CMD_W-1:0]        i_in_tuser,
    output logic [OUT_TDATA_W-1:0] o_out_tdata,
    output logic                   o_out_tvalid,
    input  wire                    i_out_tready
);

    localparam int IDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
    localparam int SW    = ((CNT_W > 6) ? CNT_W : 6) + 1;
    localparam logic [15:0] ONE = 16'(1 << FRAC_BITS);

    t_cmd        r_cmd;
    logic [5:0]  r_slot;
    t_vec3       r_pa, r_pb;
    t_mat        r_rows;
    t_box        r_char;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_obj;
    logic [5:0]  r_new_slot;

    t_box        mem_box [MAX_OBJECTS];
    t_mat        mem_mat [MAX_OBJECTS];
    t_box        r_rd_box;
    t_mat        r_rd_mat;

    logic               r_sel_obj;
    logic signed [31:0] r_prod;
    logic               r_prod_vld;
    logic [1:0]         r_prod_row;
    logic signed [33:0] r_acc [4];
    t_vec3              r_olo, r_ohi, r_clo, r_chi;

    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_valid;

    t_box        src_box, cover_box, grow_box;
    t_mat        src_mat, ident;
    logic [15:0] p_sel;
    logic [2:0]  busy;
    logic [15:0] quo [3];
    logic [2:0]  ax_ok;
    logic [IDX_W-1:0] wr_addr;
    t_mat        wr_mat;

    // Input item register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd  <= t_cmd'(i_in_tuser);
            r_slot <= i_in_tdata[OFS_SLOT +: 6];
            r_pa   <= i_in_tdata[OFS_MIN +: 48];
            r_pb   <= i_in_tdata[OFS_MAX +: 48];
            r_rows <= i_in_tdata[OFS_ROWS +: 256];
        end
    end

    // Box covering the two input points, and the grown character box.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            cover_box.lo[a] = ($signed(r_pa[a]) < $signed(r_pb[a])) ? r_pa[a] : r_pb[a];
            cover_box.hi[a] = ($signed(r_pa[a]) > $signed(r_pb[a])) ? r_pa[a] : r_pb[a];
            grow_box.lo[a]  = ($signed(cover_box.lo[a]) < $signed(r_char.lo[a])) ?
                              cover_box.lo[a] : r_char.lo[a];
            grow_box.hi[a]  = ($signed(cover_box.hi[a]) > $signed(r_char.hi[a])) ?
                              cover_box.hi[a] : r_char.hi[a];
        end
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                ident[r][c] = (r == c) ? ONE : 16'h0000;
            end
        end
        wr_addr = i_cmd.set_mat ? IDX_W'(r_slot) : IDX_W'(r_count);
        wr_mat  = i_cmd.set_mat ? r_rows : ident;
    end

    // Character box and object count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char.lo <= {3{POS_MAX}};
            r_char.hi <= {3{NEG_MIN}};
            r_count   <= '0;
        end else begin
            if (i_cmd.grow) begin
                r_char <= grow_box;
            end else if (i_cmd.store_char) begin
                r_char.lo <= r_olo;
                r_char.hi <= r_ohi;
            end
            if (i_cmd.add_obj) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // Object stores: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_obj) begin
            mem_box[wr_addr] <= cover_box;
        end
        if (i_cmd.add_obj || i_cmd.set_mat) begin
            mem_mat[wr_addr] <= wr_mat;
        end
        if (i_cmd.rd_en) begin
            r_rd_box <= mem_box[r_obj];
            r_rd_mat <= mem_mat[r_obj];
        end
        if (i_cmd.add_obj) begin
            r_new_slot <= 6'(r_count);
        end
    end

    // Object index used while scanning the table.
    always_ff @(posedge i_clk) begin
        if (i_cmd.obj_clr) begin
            r_obj <= '0;
        end else if (i_cmd.obj_inc) begin
            r_obj <= r_obj + IDX_W'(1);
        end
    end

    // Corner coordinate and matrix entry for the shared multiplier.
    always_comb begin
        src_box = r_sel_obj ? r_rd_box : r_char;
        src_mat = r_sel_obj ? r_rd_mat : r_rows;
        case (i_cmd.mac_col)
            2'd0:    p_sel = i_cmd.corner[0] ? src_box.hi[0] : src_box.lo[0];
            2'd1:    p_sel = i_cmd.corner[1] ? src_box.hi[1] : src_box.lo[1];
            2'd2:    p_sel = i_cmd.corner[2] ? src_box.hi[2] : src_box.lo[2];
            default: p_sel = ONE;
        endcase
    end

    // Multiply into the product register, then accumulate in the cycle after.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.mac_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod     <= $signed(src_mat[i_cmd.mac_row][i_cmd.mac_col]) * $signed(p_sel);
        r_prod_row <= i_cmd.mac_row;
        if (i_cmd.acc_clr) begin
            for (int r = 0; r < 4; r++) begin
                r_acc[r] <= '0;
            end
        end else if (r_prod_vld) begin
            r_acc[r_prod_row] <= r_acc[r_prod_row] + {{2{r_prod[31]}}, r_prod};
        end
    end

    // One divider per axis, all sharing w as divisor.
    for (genvar a = 0; a < 3; a++) begin : g_div
        aact_div #(
            .FRAC_BITS(FRAC_BITS)
        ) u_div (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_start(i_cmd.div_start),
            .i_num  (r_acc[a]),
            .i_den  (r_acc[3]),
            .o_busy (busy[a]),
            .o_quo  (quo[a])
        );
    end

    // Transformed box collection and the saved character box.
    always_ff @(posedge i_clk) begin
        if (i_cmd.box_init) begin
            r_olo     <= {3{POS_MAX}};
            r_ohi     <= {3{NEG_MIN}};
            r_sel_obj <= i_cmd.sel_obj;
        end else if (i_cmd.minmax) begin
            for (int a = 0; a < 3; a++) begin
                if ($signed(quo[a]) < $signed(r_olo[a])) begin
                    r_olo[a] <= quo[a];
                end
                if ($signed(quo[a]) > $signed(r_ohi[a])) begin
                    r_ohi[a] <= quo[a];
                end
            end
        end
        if (i_cmd.store_ctx) begin
            r_clo <= r_olo;
            r_chi <= r_ohi;
        end
    end

    // Inclusive overlap on each axis.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            ax_ok[a] = (($signed(r_clo[a]) >= $signed(r_olo[a])) &&
                        ($signed(r_clo[a]) <= $signed(r_ohi[a]))) ||
                       (($signed(r_olo[a]) >= $signed(r_clo[a])) &&
                        ($signed(r_olo[a]) <= $signed(r_chi[a])));
        end
    end

    // Output register: status, new_slot, hit, hit_slot from bit 0 up.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            case (i_cmd.res_kind)
                RES_ADD:     r_out_data <= {7'd0, 1'b0, r_new_slot, STS_OK};
                RES_FULL:    r_out_data <= {7'd0, 1'b0, 6'd0, STS_FULL};
                RES_BADSLOT: r_out_data <= {7'd0, 1'b0, 6'd0, STS_BADSLOT};
                RES_HIT:     r_out_data <= {1'b0, 6'(r_obj), 1'b1, 6'd0, STS_OK};
                default:     r_out_data <= '0;
            endcase
        end
    end

    assign o_out_tdata  = r_out_data;
    assign o_out_tvalid = r_out_valid;

    // Status back to the controller.
    always_comb begin
        o_stat.cmd      = r_cmd;
        o_stat.full     = (r_count == CNT_W'(MAX_OBJECTS));
        o_stat.slot_bad = (SW'(r_slot) >= SW'(r_count));
        o_stat.obj_none = (r_count == '0);
        o_stat.obj_last = ((SW'(r_obj) + SW'(1)) == SW'(r_count));
        o_stat.div_busy = |busy;
        o_stat.overlap  = &ax_ok;
        o_stat.out_busy = r_out_valid && !i_out_tready;
    end

endmodule

`default_nettype wire

// ===== src/aact_ctrl.sv =====
// ---------------------------------------------------------------------------
// AABB collision table controller
// Sequences commands: table updates, corner-by-corner box transforms and the
// object scan of a query.
// ---------------------------------------------------------------------------
`default_nettype none

module aact_ctrl
    import aact_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state     r_state, n_state;
    logic [2:0] r_corner, n_corner;
    logic [3:0] r_mac, n_mac;
    logic       r_phase, n_phase;
    t_res       r_res_kind, n_res_kind;

    // State register and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_corner   <= '0;
            r_mac      <= '0;
            r_phase    <= 1'b0;
            r_res_kind <= RES_NONE;
        end else begin
            r_state    <= n_state;
            r_corner   <= n_corner;
            r_mac      <= n_mac;
            r_phase    <= n_phase;
            r_res_kind <= n_res_kind;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        n_corner   = r_corner;
        n_mac      = r_mac;
        n_phase    = r_phase;
        n_res_kind = r_res_kind;
        o_cmd      = '0;
        o_cmd.res_kind = r_res_kind;
        o_cmd.corner   = r_corner;
        o_cmd.mac_row  = r_mac[3:2];
        o_cmd.mac_col  = r_mac[1:0];
        o_in_ready     = (r_state == ST_IDLE);

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state    = ST_RESULT;
                n_res_kind = RES_NONE;
                n_phase    = 1'b0;
                n_corner   = '0;
                case (i_stat.cmd)
                    CMD_ADD: begin
                        if (i_stat.full) begin
                            n_res_kind = RES_FULL;
                        end else begin
                            o_cmd.add_obj = 1'b1;
                            n_res_kind    = RES_ADD;
                        end
                    end
                    CMD_SET: begin
                        if (i_stat.slot_bad) begin
                            n_res_kind = RES_BADSLOT;
                        end else begin
                            o_cmd.set_mat = 1'b1;
                        end
                    end
                    CMD_GROW: begin
                        o_cmd.grow = 1'b1;
                    end
                    CMD_XFORM, CMD_QUERY: begin
                        o_cmd.box_init = 1'b1;
                        n_state        = ST_CORNER;
                    end
                    default: begin
                        n_res_kind = RES_NONE;
                    end
                endcase
            end
            ST_CORNER: begin
                o_cmd.acc_clr = 1'b1;
                n_mac         = '0;
                n_state       = ST_MAC;
            end
            ST_MAC: begin
                o_cmd.mac_en = 1'b1;
                n_mac        = r_mac + 4'd1;
                if (r_mac == 4'd15) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_WAIT;
            end
            ST_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = ST_MINMAX;
                end
            end
            ST_MINMAX: begin
                o_cmd.minmax = 1'b1;
                n_corner     = r_corner + 3'd1;
                n_state      = (r_corner == 3'd7) ? ST_BOX_DONE : ST_CORNER;
            end
            ST_BOX_DONE: begin
                n_state = ST_RESULT;
                if (i_stat.cmd == CMD_XFORM) begin
                    o_cmd.store_char = 1'b1;
                    n_res_kind       = RES_NONE;
                end else if (!r_phase) begin
                    // Character box done; start the object scan.
                    o_cmd.store_ctx = 1'b1;
                    n_phase         = 1'b1;
                    if (i_stat.obj_none) begin
                        n_res_kind = RES_NONE;
                    end else begin
                        o_cmd.obj_clr = 1'b1;
                        n_state       = ST_OBJ_RD;
                    end
                end else if (i_stat.overlap) begin
                    n_res_kind = RES_HIT;
                end else if (i_stat.obj_last) begin
                    n_res_kind = RES_NONE;
                end else begin
                    o_cmd.obj_inc = 1'b1;
                    n_state       = ST_OBJ_RD;
                end
            end
            ST_OBJ_RD: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.box_init = 1'b1;
                o_cmd.sel_obj  = 1'b1;
                n_corner       = '0;
                n_state        = ST_CORNER;
            end
            ST_RESULT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
